### sv/tcf_pkg.sv
// ----------------------------------------------------------------------------
// tcf_pkg
// Types, codes and constants shared by the Telnet command filter modules.
// ----------------------------------------------------------------------------
package tcf_pkg;

   // Telnet command codes and special characters
   localparam logic [7:0] CODE_IAC  = 8'hFF;
   localparam logic [7:0] CODE_DONT = 8'hFE;
   localparam logic [7:0] CODE_DO   = 8'hFD;
   localparam logic [7:0] CODE_WONT = 8'hFC;
   localparam logic [7:0] CODE_WILL = 8'hFB;
   localparam logic [7:0] CODE_SB   = 8'hFA;
   localparam logic [7:0] CODE_SE   = 8'hF0;
   localparam logic [7:0] CHAR_CR   = 8'h0D;
   localparam logic [7:0] CHAR_LF   = 8'h0A;
   localparam logic [7:0] CHAR_NUL  = 8'h00;

   // queue between parser and emitter
   localparam int QueueDepth = 4;
   localparam int QueuePtrW  = $clog2(QueueDepth);
   localparam int QueueCntW  = $clog2(QueueDepth + 1);

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       link_up;
   } req_type;

   typedef struct packed {
      logic        destination;
      logic [7:0]  out_byte;
      logic        last;
      logic [31:0] received_total;
   } rsp_type;

   typedef enum logic [2:0] {
      PS_NORMAL = 3'd0,
      PS_IAC    = 3'd1,
      PS_VERB   = 3'd2,
      PS_SB     = 3'd3,
      PS_SB_IAC = 3'd4
   } parse_state_type;

   typedef enum logic {
      ACT_DATA   = 1'b0,
      ACT_REFUSE = 1'b1
   } action_type;

   // one queued job for the emitter
   typedef struct packed {
      action_type  action;
      logic [7:0]  data_byte;   // data byte, or option byte of a refusal
      logic [7:0]  reply_verb;  // DONT or WONT for a refusal
      logic [31:0] total;
   } job_type;

   typedef enum logic [1:0] {
      BEAT_FIRST  = 2'd0,
      BEAT_SECOND = 2'd1,
      BEAT_THIRD  = 2'd2
   } beat_type;

endpackage

### sv/tcf_parser.sv
// ----------------------------------------------------------------------------
// tcf_parser
// Front end: takes received bytes, tracks Telnet parse state and CR handling,
// and turns each byte into at most one job for the emitter.
// ----------------------------------------------------------------------------
module tcf_parser import tcf_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   input  logic    queue_full,
   output logic    push,
   output job_type push_job
);

   parse_state_type state_ff, state_in;
   logic [7:0]      verb_ff, verb_in;
   logic            cr_ff, cr_in;
   logic [31:0]     count_ff, count_in;

   logic       accept;
   logic [7:0] b;
   logic       deliver;
   logic [7:0] deliver_byte;
   logic       refuse;

   assign req_ready = !queue_full;
   assign accept    = req_valid && !queue_full;
   assign b         = req_data.rx_byte;

   // next state
   always_comb begin
      state_in = state_ff;
      verb_in  = verb_ff;
      cr_in    = cr_ff;
      case (state_ff)
         PS_NORMAL: begin
            if (b == CODE_IAC) begin
               cr_in    = 1'b0;
               state_in = PS_IAC;
            end else if ((b == CHAR_NUL || b == CHAR_LF) && cr_ff) begin
               cr_in = 1'b0;
            end else begin
               cr_in = (b == CHAR_CR);
            end
         end
         PS_IAC: begin
            if (b == CODE_IAC) begin
               state_in = PS_NORMAL;
            end else if (b inside {[CODE_WILL:CODE_DONT]}) begin
               verb_in  = b;
               state_in = PS_VERB;
            end else if (b == CODE_SB) begin
               state_in = PS_SB;
            end else begin
               state_in = PS_NORMAL;
            end
         end
         PS_VERB:   state_in = PS_NORMAL;
         PS_SB: begin
            if (b == CODE_IAC) state_in = PS_SB_IAC;
         end
         PS_SB_IAC: state_in = (b == CODE_IAC) ? PS_SB : PS_NORMAL;
         default:   state_in = PS_NORMAL;
      endcase
   end

   // outputs
   always_comb begin
      deliver      = 1'b0;
      deliver_byte = b;
      refuse       = 1'b0;
      case (state_ff)
         PS_NORMAL: begin
            deliver = (b != CODE_IAC) && !((b == CHAR_NUL || b == CHAR_LF) && cr_ff);
         end
         PS_IAC: begin
            deliver      = (b == CODE_IAC);
            deliver_byte = CODE_IAC;
         end
         PS_VERB: begin
            refuse = (verb_ff == CODE_WILL || verb_ff == CODE_DO) && req_data.link_up;
         end
         default: begin
            deliver = 1'b0;
         end
      endcase
   end

   assign count_in = (accept && deliver) ? count_ff + 32'd1 : count_ff;

   assign push                = accept && (deliver || refuse);
   assign push_job.action     = refuse ? ACT_REFUSE : ACT_DATA;
   assign push_job.data_byte  = deliver_byte;
   assign push_job.reply_verb = (verb_ff == CODE_WILL) ? CODE_DONT : CODE_WONT;
   assign push_job.total      = count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= PS_NORMAL;
         verb_ff  <= 8'h00;
         cr_ff    <= 1'b0;
         count_ff <= 32'd0;
      end else begin
         if (accept) begin
            state_ff <= state_in;
            verb_ff  <= verb_in;
            cr_ff    <= cr_in;
         end
         count_ff <= count_in;
      end
   end

endmodule

### sv/tcf_queue.sv
// ----------------------------------------------------------------------------
// tcf_queue
// Small job FIFO between parser and emitter.
// ----------------------------------------------------------------------------
module tcf_queue import tcf_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   output logic    head_valid,
   output job_type head_job,
   input  logic    pop
);

   job_type              slot_ff [QueueDepth];
   logic [QueuePtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QueueCntW-1:0] count_ff, count_in;

   logic do_push, do_pop;

   assign full       = (count_ff == QueueCntW'(QueueDepth));
   assign head_valid = (count_ff != '0);
   assign head_job   = slot_ff[rd_ptr_ff];

   assign do_push = push && !full;
   assign do_pop  = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QueuePtrW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QueuePtrW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) count_in = count_ff + QueueCntW'(1);
      else if (!do_push && do_pop) count_in = count_ff - QueueCntW'(1);
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### sv/tcf_emitter.sv
// ----------------------------------------------------------------------------
// tcf_emitter
// Back end: turns queued jobs into result words, one word for a data byte and
// three for a refusal, into a registered output stage.
// ----------------------------------------------------------------------------
module tcf_emitter import tcf_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    head_valid,
   input  job_type head_job,
   output logic    pop,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   beat_type beat_ff, beat_in;
   logic     rsp_valid_ff, rsp_valid_in;
   rsp_type  rsp_data_ff, rsp_data_in;

   logic load;
   logic job_done;

   // output register takes a new word when empty or being drained
   assign load     = !rsp_valid_ff || rsp_ready;
   assign job_done = (head_job.action == ACT_DATA) || (beat_ff == BEAT_THIRD);
   assign pop      = load && head_valid && job_done;

   // next beat
   always_comb begin
      beat_in = beat_ff;
      if (load && head_valid) begin
         if (job_done) begin
            beat_in = BEAT_FIRST;
         end else begin
            case (beat_ff)
               BEAT_FIRST:  beat_in = BEAT_SECOND;
               BEAT_SECOND: beat_in = BEAT_THIRD;
               default:     beat_in = BEAT_FIRST;
            endcase
         end
      end
   end

   // word for the current beat
   always_comb begin
      rsp_data_in.received_total = head_job.total;
      if (head_job.action == ACT_DATA) begin
         rsp_data_in.destination = 1'b0;
         rsp_data_in.out_byte    = head_job.data_byte;
         rsp_data_in.last        = 1'b1;
      end else begin
         rsp_data_in.destination = 1'b1;
         case (beat_ff)
            BEAT_FIRST: begin
               rsp_data_in.out_byte = CODE_IAC;
               rsp_data_in.last     = 1'b0;
            end
            BEAT_SECOND: begin
               rsp_data_in.out_byte = head_job.reply_verb;
               rsp_data_in.last     = 1'b0;
            end
            default: begin
               rsp_data_in.out_byte = head_job.data_byte;
               rsp_data_in.last     = 1'b1;
            end
         endcase
      end
      rsp_valid_in = load ? head_valid : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff      <= BEAT_FIRST;
         rsp_valid_ff <= 1'b0;
      end else begin
         beat_ff      <= beat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && head_valid) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### sv/telnet_command_filter.sv
// ----------------------------------------------------------------------------
// telnet_command_filter
// Telnet receive filter: passes data bytes to the host, refuses options.
// ----------------------------------------------------------------------------
// Accepts one received byte per cycle while the queue has room. Data bytes
// come out as one host word (destination 0) carrying the running delivered
// count; a WILL or DO from the peer with the link up comes out as three
// network words (IAC, DONT/WONT, option). The parser classifies each byte
// in the cycle it is accepted and pushes a job into a 4-entry queue; the
// emitter drains that queue at one output word per cycle while rsp_ready
// is high, so a refusal holds the back end for three words while the parser
// keeps taking bytes until the queue fills; jobs pass the queue and then the
// output register. req_ready drops only when the queue is full.
module telnet_command_filter import tcf_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    push;
   job_type push_job;
   logic    queue_full;
   logic    head_valid;
   job_type head_job;
   logic    pop;

   tcf_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .queue_full (queue_full),
      .push       (push),
      .push_job   (push_job)
   );

   tcf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop)
   );

   tcf_emitter u_emitter (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

   // host words always end their item
   a_host_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.destination |-> rsp_data.last)
      else $error("host word without last");

   // a refusal burst runs without gaps once started
   a_burst_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_data.destination && !rsp_data.last
      |=> rsp_valid && rsp_data.destination)
      else $error("refusal burst broken");

   // non-final network words are IAC or the reply verb
   a_burst_bytes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.destination && !rsp_data.last
      |-> rsp_data.out_byte == CODE_IAC || rsp_data.out_byte == CODE_DONT
          || rsp_data.out_byte == CODE_WONT)
      else $error("bad refusal byte");

   // consecutive host words count up by one
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_data.destination
      ##1 rsp_valid && !rsp_data.destination && !$stable(rsp_data)
      |-> rsp_data.received_total == $past(rsp_data.received_total) + 32'd1)
      else $error("received_total skipped");

endmodule
